/* sv/tcdsc_pkg.sv */
// Shared types and codes for the two-class degree sequence checker.
// No dependencies; imported by the cell, the chain, the top level and the checker.
package tcdsc_pkg;

    localparam int FIELD_W   = 7;
    localparam int TOTAL_W   = FIELD_W + 1;
    localparam int VERDICT_W = 3;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK     = 3'd0,
        VERDICT_DEGREE = 3'd1,
        VERDICT_ODD    = 3'd2,
        VERDICT_REDUCE = 3'd3,
        VERDICT_COUNT  = 3'd4
    } verdict_t;

    // Operation broadcast to every cell in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_SORT = 2'd2,
        CELL_STEP = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     odd_phase;   // sort phase: pairs start at odd index
        field_t   top_degree;  // largest degree for a reduction step
    } cell_cmd_t;

    // Request fields needed by the cells at load time
    typedef struct packed {
        field_t count_a;
        field_t degree_a;
        total_t total;
        field_t degree_b;
    } load_t;

endpackage

/* sv/two_class_degree_sequence_check.sv */
// A request settled by the count, degree or parity checks goes from idle straight to the done
// state; otherwise it passes through R reduction rounds, R < total, before the done state.
// The done state registers the result once no result is held or the held one is taken.
// Each round is a full odd-even transposition sort of MAX_VERTICES phases plus one step.
// One request at a time; the next is taken the cycle after the result registers, even if it waits.
// Reset (rst_n, async, active low) clears control; cell contents load per request.
module two_class_degree_sequence_check #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  tcdsc_pkg::field_t    count_a,
    input  tcdsc_pkg::field_t    degree_a,
    input  tcdsc_pkg::field_t    count_b,
    input  tcdsc_pkg::field_t    degree_b,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 graph_exists,
    output tcdsc_pkg::verdict_t  verdict
);
    import tcdsc_pkg::*;

    localparam int PH_W = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(MAX_VERTICES - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SORT = 4'b0010,
        ST_STEP = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [PH_W-1:0] phase_reg, phase_next;
    total_t          total_reg, total_next;
    verdict_t        result_reg, result_next;
    logic            res_valid_reg, res_valid_next;
    verdict_t        verdict_reg, verdict_next;

    cell_cmd_t       cmd;
    load_t           load;
    field_t          head;
    logic            any_hit;

    logic            accept;
    total_t          total;
    logic            early_done;
    verdict_t        early_verdict;

    assign accept = req_valid && req_ready;
    assign total  = total_t'(count_a) + total_t'(count_b);

    // Up-front checks, in priority order
    always_comb
    begin
        early_done    = 1'b1;
        early_verdict = VERDICT_OK;
        if (int'(total) > MAX_VERTICES)
            early_verdict = VERDICT_COUNT;
        else if (total == '0)
            early_verdict = VERDICT_OK;
        else if ((count_a != '0 && total_t'(degree_a) >= total) ||
                 (count_b != '0 && total_t'(degree_b) >= total))
            early_verdict = VERDICT_DEGREE;
        else if ((count_a[0] & degree_a[0]) ^ (count_b[0] & degree_b[0]))
            early_verdict = VERDICT_ODD;
        else
            early_done = 1'b0;
    end

    assign load = '{count_a: count_a, degree_a: degree_a, total: total,
                    degree_b: degree_b};

    // Controller
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        total_next     = total_reg;
        result_next    = result_reg;
        res_valid_next = res_valid_reg;
        verdict_next   = verdict_reg;
        cmd            = '{op: CELL_HOLD, odd_phase: phase_reg[0], top_degree: head};
        req_ready      = 1'b0;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (accept)
                begin
                    total_next = total;
                    phase_next = '0;
                    if (early_done)
                    begin
                        result_next = early_verdict;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cmd.op     = CELL_LOAD;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT:
            begin
                cmd.op     = CELL_SORT;
                phase_next = phase_reg + 1'b1;
                if (phase_reg == LAST_PHASE)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                phase_next = '0;
                if (head == '0)
                begin
                    result_next = VERDICT_OK;
                    state_next  = ST_DONE;
                end
                else if (total_t'(head) >= total_reg || any_hit)
                begin
                    result_next = VERDICT_REDUCE;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.op     = CELL_STEP;
                    state_next = ST_SORT;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    verdict_next   = result_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg   <= phase_next;
        total_reg   <= total_next;
        result_reg  <= result_next;
        verdict_reg <= verdict_next;
    end

    tcdsc_chain #(
        .NUM_CELLS (MAX_VERTICES)
    ) u_chain (
        .clk     (clk),
        .cmd     (cmd),
        .load    (load),
        .head    (head),
        .any_hit (any_hit)
    );

    assign res_valid    = res_valid_reg;
    assign verdict      = verdict_reg;
    assign graph_exists = (verdict_reg == VERDICT_OK);

endmodule

/* sv/tcdsc_cell.sv */
// One degree cell: holds a degree, compare-exchanges with a neighbor,
// and applies the Havel-Hakimi decrement. Depends on tcdsc_pkg.
module tcdsc_cell #(
    parameter int INDEX     = 0,
    parameter int NUM_CELLS = 64
) (
    input  logic                  clk,
    input  tcdsc_pkg::cell_cmd_t  cmd,
    input  tcdsc_pkg::load_t      load,
    input  tcdsc_pkg::field_t     left_value,
    input  tcdsc_pkg::field_t     right_value,
    output tcdsc_pkg::field_t     value,
    output logic                  hit
);
    import tcdsc_pkg::*;

    localparam bit HAS_LEFT  = (INDEX > 0);
    localparam bit HAS_RIGHT = (INDEX < NUM_CELLS - 1);
    localparam bit IS_ODD    = ((INDEX % 2) == 1);

    field_t value_reg;
    field_t value_next;
    logic   in_range;
    logic   pair_right;
    logic   pair_left;

    // Cell lies in 1..d of the current reduction round
    assign in_range = (INDEX != 0) && (INDEX <= int'(cmd.top_degree));
    assign hit      = in_range && (value_reg == '0);

    assign pair_right = HAS_RIGHT && (IS_ODD == cmd.odd_phase);
    assign pair_left  = HAS_LEFT  && (IS_ODD != cmd.odd_phase);

    // Next value per broadcast operation
    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            CELL_LOAD:
            begin
                if (INDEX < int'(load.count_a))
                    value_next = load.degree_a;
                else if (INDEX < int'(load.total))
                    value_next = load.degree_b;
                else
                    value_next = '0;
            end
            CELL_SORT:
            begin
                // descending order: left of a pair keeps the larger value
                if (pair_right)
                    value_next = (right_value > value_reg) ? right_value : value_reg;
                else if (pair_left)
                    value_next = (left_value < value_reg) ? left_value : value_reg;
            end
            CELL_STEP:
            begin
                if (INDEX == 0)
                    value_next = '0;
                else if (in_range)
                    value_next = value_reg - field_t'(1);
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

/* sv/tcdsc_chain.sv */
// Row of degree cells wired to their neighbors, with the head value and
// the zero-hit flag collected for the controller. Depends on tcdsc_pkg, tcdsc_cell.
module tcdsc_chain #(
    parameter int NUM_CELLS = 64
) (
    input  logic                  clk,
    input  tcdsc_pkg::cell_cmd_t  cmd,
    input  tcdsc_pkg::load_t      load,
    output tcdsc_pkg::field_t     head,
    output logic                  any_hit
);
    import tcdsc_pkg::*;

    field_t                 values [NUM_CELLS];
    logic [NUM_CELLS-1:0]   hits;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        field_t left_value;
        field_t right_value;

        if (i > 0)
        begin : g_left
            assign left_value = values[i-1];
        end
        else
        begin : g_no_left
            assign left_value = '0;
        end

        if (i < NUM_CELLS - 1)
        begin : g_right
            assign right_value = values[i+1];
        end
        else
        begin : g_no_right
            assign right_value = '0;
        end

        tcdsc_cell #(
            .INDEX     (i),
            .NUM_CELLS (NUM_CELLS)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .load        (load),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (values[i]),
            .hit         (hits[i])
        );
    end

    assign head    = values[0];
    assign any_hit = |hits;

endmodule

/* sv/tcdsc_checker.sv */
// Port-level checks for the degree sequence checker, bound to the top level.
// Depends on tcdsc_pkg and two_class_degree_sequence_check.
module tcdsc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic                 graph_exists,
    input tcdsc_pkg::verdict_t  verdict
);
    import tcdsc_pkg::*;

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(verdict) && $stable(graph_exists))
        else $error("result changed while stalled");

    // Existence flag agrees with the reason code
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (graph_exists == (verdict == VERDICT_OK)))
        else $error("graph_exists disagrees with verdict");

    // Only defined reason codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (verdict == VERDICT_OK || verdict == VERDICT_DEGREE ||
                       verdict == VERDICT_ODD || verdict == VERDICT_REDUCE ||
                       verdict == VERDICT_COUNT))
        else $error("undefined verdict code");

    // One request in flight: ready drops right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");

endmodule

bind two_class_degree_sequence_check tcdsc_checker u_tcdsc_checker (.*);
